/* hdl/gts_pkg.sv */
// Shared types, constants and helpers for the gripper timed sequencer.
`timescale 1ns / 1ps

package gts_pkg;

  // Field and register widths
  localparam int unsigned StateNumW = 4;
  localparam int unsigned NumStates = 16;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned ElapsedW  = 17;
  localparam int unsigned SpeedW    = 16;
  localparam int unsigned ThrW      = 9;
  localparam int unsigned NumCfg    = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned PaddrW    = 5;
  localparam int unsigned PdataW    = 32;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 24;

  // Default eject drive, signed Q1.15
  localparam logic signed [SpeedW-1:0] EjectSpeedDef = -16'sd32768;

  // Eject throttle, Q0.8 (0.95, 0.25, 0.50)
  localparam logic [ThrW-1:0] ThrUp     = 9'd243;
  localparam logic [ThrW-1:0] ThrDown   = 9'd64;
  localparam logic [ThrW-1:0] ThrCentre = 9'd128;

  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};

  // Input commands
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_FORCE  = 2'd1,
    CMD_VACUUM = 2'd2
  } cmd_e;

  // D-pad codes
  typedef enum logic [1:0] {
    POV_UP   = 2'd0,
    POV_DOWN = 2'd1
  } pov_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_READ_SENSOR   = 3'd0,
    CFG_CLOSE_CLAW    = 3'd1,
    CFG_STOP_MOTOR    = 3'd2,
    CFG_FLOOR_EJECT   = 3'd3,
    CFG_PLUNGER       = 3'd4,
    CFG_PLUNGER_RET   = 3'd5,
    CFG_SCALE_CLOSE   = 3'd6,
    CFG_INTAKE_SPEED  = 3'd7
  } cfg_idx_e;

  // Sequencer states, one-hot; bit position is the state number
  typedef enum logic [NumStates-1:0] {
    ST_IDLE  = 16'h0001,
    ST_OI_A  = 16'h0002,
    ST_OI_B  = 16'h0004,
    ST_OI_C  = 16'h0008,
    ST_OI_D  = 16'h0010,
    ST_CI_A  = 16'h0020,
    ST_CI_B  = 16'h0040,
    ST_CI_C  = 16'h0080,
    ST_FE1_A = 16'h0100,
    ST_FE1_B = 16'h0200,
    ST_FE2_A = 16'h0400,
    ST_FE2_B = 16'h0800,
    ST_SE_A  = 16'h1000,
    ST_SE_B  = 16'h2000,
    ST_SE_C  = 16'h4000,
    ST_SE_D  = 16'h8000
  } seq_state_e;

  // Result beat fields
  typedef struct packed {
    logic                     cube_seen;
    logic                     vacuum_on;
    logic                     plunger_extend;
    logic                     claw_open;
    logic signed [SpeedW-1:0] motor_drive;
    logic [StateNumW-1:0]     seq_state_out;
  } out_beat_t;

  // Encode a one-hot state to its state number
  function automatic logic [StateNumW-1:0] state_num(input logic [NumStates-1:0] oh);
    logic [StateNumW-1:0] num;
    num = '0;
    for (int i = 0; i < NumStates; i++) begin
      if (oh[i]) begin
        num = num | StateNumW'(i);
      end
    end
    return num;
  endfunction

endpackage

/* hdl/gripper_timed_sequencer_core.sv */
// Top level of the gripper timed sequencer: config registers, state machine, result register.
`timescale 1ns / 1ps

// Takes one beat per clock cycle while s_axis_tready is high: a tick, a forced state or a
// vacuum write. Each accepted beat updates the sequencer state and the latched actuator
// registers and loads one result beat into the output register at the same clock edge.
// The input side stays ready while the result register is empty or being drained, so the
// sustained rate is one beat per cycle, limited only by the result register handshake. The
// user must write delays over the APB port only while the block is idle; the block does not
// enforce it. A timed state leaves once its saturating 17-bit tick count exceeds the delay.
module gripper_timed_sequencer_core #(
  parameter logic signed [gts_pkg::SpeedW-1:0] EJECT_SPEED = gts_pkg::EjectSpeedDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [3:0] new_state, [4] vacuum_value, [5] cube_present, [7:6] pov_code
  input  logic [gts_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]                    s_axis_tuser,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [3:0] seq_state_out, [19:4] motor_drive, [20] claw_open, [21] plunger_extend,
  // [22] vacuum_on, [23] cube_seen
  output logic [gts_pkg::OutDataW-1:0]  m_axis_tdata,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gts_pkg::PaddrW-1:0]    paddr,
  input  logic [gts_pkg::PdataW-1:0]    pwdata,
  output logic [gts_pkg::PdataW-1:0]    prdata,
  output logic                          pready
);
  import gts_pkg::*;

  logic [DelayW-1:0]          cfg_q [NumCfg];
  logic [CfgIdxW-1:0]         cfg_idx;
  logic                       cfg_wr;

  seq_state_e                 st_q, st_d;
  logic [ElapsedW-1:0]        el_q, el_d, el_inc;
  logic signed [SpeedW-1:0]   motor_q, motor_d;
  logic                       claw_q, claw_d;
  logic                       plunger_q, plunger_d;
  logic                       vac_q, vac_d;

  logic                       out_valid_q;
  out_beat_t                  out_q, out_d;

  logic                       accept;
  cmd_e                       cmd;
  logic [StateNumW-1:0]       in_state;
  logic                       in_vac;
  logic                       in_cube;
  logic [1:0]                 in_pov;
  logic [ThrW-1:0]            thr;
  logic signed [SpeedW+ThrW-1:0] eject_prod;
  logic signed [SpeedW-1:0]   eject_drive;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[PaddrW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = {{(PdataW-DelayW){1'b0}}, cfg_q[cfg_idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCfg; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      cfg_q[cfg_idx] <= pwdata[DelayW-1:0];
    end
  end

  // Unpack the input beat
  assign accept   = s_axis_tvalid & s_axis_tready;
  assign cmd      = cmd_e'(s_axis_tuser);
  assign in_state = s_axis_tdata[3:0];
  assign in_vac   = s_axis_tdata[4];
  assign in_cube  = s_axis_tdata[5];
  assign in_pov   = s_axis_tdata[7:6];

  // Scale the eject speed by the D-pad throttle, floor toward minus infinity
  always_comb begin
    case (in_pov)
      POV_UP:   thr = ThrUp;
      POV_DOWN: thr = ThrDown;
      default:  thr = ThrCentre;
    endcase
  end
  assign eject_prod  = EJECT_SPEED * $signed({1'b0, thr[ThrW-2:0]});
  assign eject_drive = eject_prod[SpeedW+7:8];

  // Saturating tick counter
  assign el_inc = (el_q == ElapsedMax) ? el_q : el_q + 1'b1;

  // Advance the sequencer for one accepted beat
  always_comb begin
    st_d      = st_q;
    el_d      = el_q;
    motor_d   = motor_q;
    claw_d    = claw_q;
    plunger_d = plunger_q;
    vac_d     = vac_q;
    if (accept) begin
      unique case (cmd)
        CMD_TICK: begin
          el_d = el_inc;
          unique case (st_q)
            ST_IDLE: begin
              motor_d   = '0;
              plunger_d = 1'b0;
              vac_d     = 1'b0;
              claw_d    = 1'b0;
            end
            ST_OI_A: begin
              motor_d   = $signed(cfg_q[CFG_INTAKE_SPEED]);
              plunger_d = 1'b0;
              vac_d     = 1'b0;
              claw_d    = 1'b1;
              el_d      = '0;
              st_d      = ST_OI_B;
            end
            ST_OI_B: begin
              if (el_inc > {1'b0, cfg_q[CFG_READ_SENSOR]} && in_cube) begin
                el_d = '0;
                st_d = ST_OI_C;
              end
            end
            ST_OI_C: begin
              if (el_inc > {1'b0, cfg_q[CFG_CLOSE_CLAW]}) begin
                el_d   = '0;
                claw_d = 1'b0;
                st_d   = ST_OI_D;
              end
            end
            ST_OI_D, ST_CI_C: begin
              if (el_inc > {1'b0, cfg_q[CFG_STOP_MOTOR]}) begin
                st_d = ST_IDLE;
              end
            end
            ST_CI_A: begin
              motor_d   = $signed(cfg_q[CFG_INTAKE_SPEED]);
              plunger_d = 1'b0;
              vac_d     = 1'b0;
              claw_d    = 1'b0;
              st_d      = ST_CI_B;
            end
            ST_CI_B: begin
              if (in_cube) begin
                el_d = '0;
                st_d = ST_CI_C;
              end
            end
            ST_FE1_A: begin
              motor_d   = eject_drive;
              plunger_d = 1'b0;
              vac_d     = 1'b0;
              claw_d    = 1'b0;
              el_d      = '0;
              st_d      = ST_FE1_B;
            end
            ST_FE1_B, ST_FE2_B: begin
              if (el_inc > {1'b0, cfg_q[CFG_FLOOR_EJECT]}) begin
                st_d = ST_IDLE;
              end
            end
            // Open the claw and hand over to the first floor eject's timed phase
            ST_FE2_A: begin
              claw_d = 1'b1;
              el_d   = '0;
              st_d   = ST_FE1_B;
            end
            ST_SE_A: begin
              motor_d = '0;
              vac_d   = 1'b0;
              claw_d  = 1'b1;
              el_d    = '0;
              st_d    = ST_SE_B;
            end
            ST_SE_B: begin
              if (el_inc > {1'b0, cfg_q[CFG_PLUNGER]}) begin
                plunger_d = 1'b1;
                el_d      = '0;
                st_d      = ST_SE_C;
              end
            end
            ST_SE_C: begin
              if (el_inc > {1'b0, cfg_q[CFG_PLUNGER_RET]}) begin
                plunger_d = 1'b0;
                vac_d     = 1'b1;
                el_d      = '0;
                st_d      = ST_SE_D;
              end
            end
            ST_SE_D: begin
              if (el_inc > {1'b0, cfg_q[CFG_SCALE_CLOSE]}) begin
                st_d = ST_IDLE;
              end
            end
            default: begin
              st_d = st_q;
            end
          endcase
        end
        CMD_FORCE: begin
          st_d = seq_state_e'(NumStates'(1) << in_state);
        end
        CMD_VACUUM: begin
          vac_d = in_vac;
        end
        default: begin
          st_d = st_q;
        end
      endcase
    end
  end

  // Hold sequencer state and latched actuator outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      el_q      <= '0;
      motor_q   <= '0;
      claw_q    <= 1'b0;
      plunger_q <= 1'b0;
      vac_q     <= 1'b0;
    end else begin
      st_q      <= st_d;
      el_q      <= el_d;
      motor_q   <= motor_d;
      claw_q    <= claw_d;
      plunger_q <= plunger_d;
      vac_q     <= vac_d;
    end
  end

  // Build the result beat from the updated state
  always_comb begin
    out_d.seq_state_out  = state_num(st_d);
    out_d.motor_drive    = motor_d;
    out_d.claw_open      = claw_d;
    out_d.plunger_extend = plunger_d;
    out_d.vacuum_on      = vac_d;
    out_d.cube_seen      = in_cube;
  end

  // Result register: refill whenever it is empty or being drained
  assign s_axis_tready = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

/* tb/gts_actuator_checker.sv */
// Checker for the gripper sequencer: predicts each result beat and compares it with the block.
`timescale 1ns / 1ps

module gts_actuator_checker
  import gts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // [3:0] new_state, [4] vacuum_value, [5] cube_present, [7:6] pov_code
  input  logic [InDataW-1:0]   s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]           s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [3:0] seq_state_out, [19:4] motor_drive, [20] claw_open, [21] plunger_extend,
  // [22] vacuum_on, [23] cube_seen
  input  logic [OutDataW-1:0]  m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrW-1:0]    paddr,
  input  logic [PdataW-1:0]    pwdata,
  input  logic                 pready,
  output int unsigned          err_count_o,
  output int unsigned          pending_o
);

  // Shadow of the sequencer state and its settings
  seq_state_e          cur_state = ST_IDLE;
  logic [ElapsedW-1:0] elapsed   = '0;
  logic [SpeedW-1:0]   motor     = '0;
  logic                claw      = 1'b0;
  logic                plunger   = 1'b0;
  logic                vacuum    = 1'b0;
  logic [DelayW-1:0]   cfg_regs [NumCfg] = '{default: '0};

  out_beat_t   actuation_q[$];
  int unsigned errors = 0;

  function automatic bit delay_done(cfg_idx_e idx);
    return elapsed > ElapsedW'(cfg_regs[idx]);
  endfunction

  // Eject speed scaled by the D-pad throttle, rounded toward minus infinity
  function automatic logic [SpeedW-1:0] eject_drive(logic [1:0] pov);
    int thr;
    int prod;
    case (pov)
      POV_UP:   thr = ThrUp;
      POV_DOWN: thr = ThrDown;
      default:  thr = ThrCentre;
    endcase
    prod = int'(EjectSpeedDef) * thr;
    return SpeedW'(prod >>> 8);
  endfunction

  // Apply one accepted beat to the shadow state and return the result it should produce
  function automatic out_beat_t step_sequencer(logic [1:0] cmd, logic [3:0] st_in,
                                               logic vac_in, logic cube, logic [1:0] pov);
    out_beat_t res;
    case (cmd)
      CMD_TICK: begin
        if (elapsed != ElapsedMax) elapsed++;
        case (cur_state)
          ST_IDLE: begin
            motor = '0; plunger = 1'b0; vacuum = 1'b0; claw = 1'b0;
          end
          ST_OI_A: begin
            motor = cfg_regs[CFG_INTAKE_SPEED]; plunger = 1'b0; vacuum = 1'b0; claw = 1'b1;
            elapsed = '0; cur_state = ST_OI_B;
          end
          ST_OI_B: if (delay_done(CFG_READ_SENSOR) && cube) begin
            elapsed = '0; cur_state = ST_OI_C;
          end
          ST_OI_C: if (delay_done(CFG_CLOSE_CLAW)) begin
            elapsed = '0; claw = 1'b0; cur_state = ST_OI_D;
          end
          ST_OI_D, ST_CI_C: if (delay_done(CFG_STOP_MOTOR)) cur_state = ST_IDLE;
          ST_CI_A: begin
            motor = cfg_regs[CFG_INTAKE_SPEED]; plunger = 1'b0; vacuum = 1'b0; claw = 1'b0;
            cur_state = ST_CI_B;
          end
          ST_CI_B: if (cube) begin
            elapsed = '0; cur_state = ST_CI_C;
          end
          ST_FE1_A: begin
            motor = eject_drive(pov); plunger = 1'b0; vacuum = 1'b0; claw = 1'b0;
            elapsed = '0; cur_state = ST_FE1_B;
          end
          ST_FE1_B, ST_FE2_B: if (delay_done(CFG_FLOOR_EJECT)) cur_state = ST_IDLE;
          // second floor eject opens the claw and falls into the first one's wait
          ST_FE2_A: begin
            claw = 1'b1; elapsed = '0; cur_state = ST_FE1_B;
          end
          ST_SE_A: begin
            motor = '0; vacuum = 1'b0; claw = 1'b1; elapsed = '0; cur_state = ST_SE_B;
          end
          ST_SE_B: if (delay_done(CFG_PLUNGER)) begin
            plunger = 1'b1; elapsed = '0; cur_state = ST_SE_C;
          end
          ST_SE_C: if (delay_done(CFG_PLUNGER_RET)) begin
            plunger = 1'b0; vacuum = 1'b1; elapsed = '0; cur_state = ST_SE_D;
          end
          default: if (delay_done(CFG_SCALE_CLOSE)) cur_state = ST_IDLE;
        endcase
      end
      CMD_FORCE:  cur_state = seq_state_e'(NumStates'(1) << st_in);
      CMD_VACUUM: vacuum = vac_in;
      default: ;
    endcase
    res.seq_state_out  = StateNumW'($clog2(cur_state));
    res.motor_drive    = motor;
    res.claw_open      = claw;
    res.plunger_extend = plunger;
    res.vacuum_on      = vacuum;
    res.cube_seen      = cube;
    return res;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare drained beats, track register writes, predict accepted beats
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t got;
    out_beat_t want;
    if (!rst_ni) begin
      cur_state = ST_IDLE;
      elapsed   = '0;
      motor     = '0;
      claw      = 1'b0;
      plunger   = 1'b0;
      vacuum    = 1'b0;
      foreach (cfg_regs[i]) cfg_regs[i] = '0;
      actuation_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_beat_t'(m_axis_tdata);
        if (actuation_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, got %h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          want = actuation_q.pop_front();
          check_field("seq_state_out", 32'(want.seq_state_out), 32'(got.seq_state_out));
          check_field("motor_drive", 32'(want.motor_drive), 32'(got.motor_drive));
          check_field("claw_open", 32'(want.claw_open), 32'(got.claw_open));
          check_field("plunger_extend", 32'(want.plunger_extend), 32'(got.plunger_extend));
          check_field("vacuum_on", 32'(want.vacuum_on), 32'(got.vacuum_on));
          check_field("cube_seen", 32'(want.cube_seen), 32'(got.cube_seen));
        end
      end
      if (psel && penable && pwrite && pready) begin
        cfg_regs[paddr[PaddrW-1:2]] = pwdata[DelayW-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        actuation_q.push_back(step_sequencer(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[4],
                                             s_axis_tdata[5], s_axis_tdata[7:6]));
      end
    end
    err_count_o <= errors;
    pending_o   <= actuation_q.size();
  end

endmodule

/* tb/tb.sv */
// Testbench top for the gripper sequencer: clock, reset, stimulus, result pacing and verdict.
`timescale 1ns / 1ps

module tb;
  import gts_pkg::*;

  localparam logic [1:0]        CmdUnused   = 2'd3;
  localparam logic [1:0]        PovCentre   = 2'd2;
  localparam logic [1:0]        PovOther    = 2'd3;
  localparam logic [DelayW-1:0] DelayMax    = '1;
  localparam logic [SpeedW-1:0] SpeedMin    = 16'h8000;
  localparam logic [SpeedW-1:0] SpeedMax    = 16'h7FFF;
  localparam int unsigned       CycleLimit  = 2_000_000;
  localparam int unsigned       NumPhases   = 6;
  localparam int unsigned       PhaseItems  = 300;
  localparam int unsigned       HoldTicks   = 40;
  localparam int unsigned       HoldCycles  = 300;
  localparam int unsigned       DrainCycles = 8;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [3:0] new_state, [4] vacuum_value, [5] cube_present, [7:6] pov_code
  logic [InDataW-1:0]  s_axis_tdata;
  // [1:0] cmd
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [3:0] seq_state_out, [19:4] motor_drive, [20] claw_open, [21] plunger_extend,
  // [22] vacuum_on, [23] cube_seen
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [PdataW-1:0]   pwdata;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  int unsigned mismatches;
  int unsigned beats_pending;
  int unsigned burst_left = 0;
  bit          gaps_on    = 1'b1;
  int unsigned hold_asked = 0;

  gripper_timed_sequencer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  gts_actuator_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .err_count_o   (mismatches),
    .pending_o     (beats_pending)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [StateNumW-1:0] state_code(seq_state_e s);
    return StateNumW'($clog2(s));
  endfunction

  // Offer one beat, idling in bursts first, and hold until it is taken
  task automatic push_beat(logic [1:0] cmd, logic [3:0] st, logic vac, logic cube,
                           logic [1:0] pov);
    int unsigned gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = ($urandom_range(9) == 0) ? 200 : $urandom_range(1, 40);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {pov, cube, vac, st};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic tick(logic cube, logic [1:0] pov);
    push_beat(CMD_TICK, 4'($urandom), 1'($urandom), cube, pov);
  endtask

  task automatic force_to(seq_state_e s);
    push_beat(CMD_FORCE, state_code(s), 1'($urandom), 1'($urandom), 2'($urandom));
  endtask

  // Drop valid and hold until every predicted beat has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (beats_pending != 0) @(posedge clk_i);
  endtask

  // Write all registers back to back over the configuration port
  task automatic program_regs(logic [DelayW-1:0] vals [NumCfg]);
    for (int i = 0; i < NumCfg; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PaddrW'(i * 4);
      pwdata  <= PdataW'(vals[i]);
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed sequences (force an entry state, then ticks), some noise
  task automatic run_phase(int unsigned count);
    int unsigned sent;
    int unsigned n;
    int unsigned r;
    seq_state_e  entry;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) < 8) begin
        case ($urandom_range(4))
          0:       entry = ST_OI_A;
          1:       entry = ST_CI_A;
          2:       entry = ST_FE1_A;
          3:       entry = ST_FE2_A;
          default: entry = ST_SE_A;
        endcase
        force_to(entry);
        n = $urandom_range(3, 30);
        for (int k = 0; k < n; k++) begin
          r = $urandom_range(99);
          if (r < 4) begin
            push_beat(CMD_VACUUM, 4'($urandom), 1'($urandom), 1'($urandom), 2'($urandom));
          end else if (r < 6) begin
            push_beat(CmdUnused, 4'($urandom), 1'($urandom), 1'($urandom), 2'($urandom));
          end else begin
            tick($urandom_range(3) == 0, 2'($urandom));
          end
        end
        sent += n + 1;
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) push_beat(2'($urandom), 4'($urandom), 1'($urandom), 1'($urandom),
                             2'($urandom));
        sent += n;
      end
    end
  endtask

  // Result side: random stall rate that changes every so often, long hold-offs on request
  initial begin : result_pacer
    int unsigned served;
    int unsigned hold_left;
    int unsigned pace;
    int unsigned stall_pct;
    served    = 0;
    hold_left = 0;
    pace      = 0;
    stall_pct = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (served != hold_asked) begin
        served    = hold_asked;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (pace == 0) begin
          pace = $urandom_range(20, 80);
          case ($urandom_range(4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 20;
            3:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        pace--;
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL gripper_timed_sequencer_core");
    $finish;
  end

  initial begin : stimulus
    logic [DelayW-1:0] regs [NumCfg];
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_TICK;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every command and state family with zero delays
    foreach (regs[i]) regs[i] = '0;
    regs[CFG_INTAKE_SPEED] = SpeedMax;
    program_regs(regs);
    tick(1'b0, POV_UP);
    push_beat(CmdUnused, 4'hF, 1'b1, 1'b1, PovOther);
    push_beat(CMD_VACUUM, 4'h0, 1'b1, 1'b0, POV_UP);
    tick(1'b1, POV_DOWN);
    force_to(ST_FE1_A);
    tick(1'b0, POV_UP);
    tick(1'b1, POV_UP);
    force_to(ST_FE1_A);
    tick(1'b0, POV_DOWN);
    force_to(ST_FE1_A);
    tick(1'b1, PovOther);
    force_to(ST_FE2_A);
    tick(1'b0, POV_UP);
    force_to(ST_FE2_B);
    tick(1'b0, POV_UP);
    force_to(ST_SE_A);
    repeat (4) tick(1'b0, PovCentre);
    force_to(ST_OI_A);
    tick(1'b0, POV_UP);
    tick(1'b1, POV_UP);
    repeat (2) tick(1'b0, POV_UP);
    force_to(ST_CI_A);
    tick(1'b0, POV_DOWN);
    tick(1'b1, POV_DOWN);
    tick(1'b0, POV_DOWN);
    wait_drained();

    // Longest floor-eject and stop-motor delays: the timed states must hold on every tick
    regs[CFG_FLOOR_EJECT]  = DelayMax;
    regs[CFG_STOP_MOTOR]   = DelayMax;
    regs[CFG_INTAKE_SPEED] = SpeedMin;
    program_regs(regs);
    gaps_on = 1'b0;
    force_to(ST_FE1_A);
    repeat (HoldTicks) tick(1'($urandom), 2'($urandom));
    force_to(ST_OI_D);
    tick(1'b0, POV_UP);
    gaps_on = 1'b1;
    wait_drained();

    // Random phases, each with its own register settings
    for (int p = 0; p < NumPhases; p++) begin
      foreach (regs[i]) begin
        regs[i] = ($urandom_range(9) == 0) ? DelayW'($urandom_range(5, 40))
                                           : DelayW'($urandom_range(4));
      end
      regs[CFG_INTAKE_SPEED] = SpeedW'($urandom);
      if (p == 0) begin
        foreach (regs[i]) regs[i] = '0;
        regs[CFG_INTAKE_SPEED] = SpeedMin;
      end else if (p == 2) begin
        foreach (regs[i]) regs[i] = DelayMax;
        regs[CFG_INTAKE_SPEED] = SpeedMax;
      end
      program_regs(regs);
      if (p == 1) begin
        // stall the result side for a long stretch while beats keep coming
        run_phase(PhaseItems / 2);
        hold_asked++;
        run_phase(PhaseItems / 2);
      end else if (p == 3) begin
        run_phase(PhaseItems / 2);
        wait_drained();
        run_phase(PhaseItems / 2);
      end else begin
        run_phase(PhaseItems);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && beats_pending == 0) begin
      $display("PASS gripper_timed_sequencer_core");
    end else begin
      $display("FAIL gripper_timed_sequencer_core");
    end
    $finish;
  end

endmodule
